>>> rtl/core/gwc_pkg.sv
// ----------------------------------------------------------------------------
// gwc_pkg
// Shared types and constants for the windowed image convolution core.
// ----------------------------------------------------------------------------
package gwc_pkg;

   // Kernel geometry
   localparam int RADIUS     = 7;
   localparam int KSIZE      = 2 * RADIUS + 1;
   localparam int TAPS       = KSIZE * KSIZE;

   // Image geometry
   localparam int MAX_WIDTH  = 1024;
   localparam int WID_W      = 11;
   localparam int HGT_W      = 13;
   localparam int WIDTH_CAP  = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
   localparam int HEIGHT_CAP = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int COLX_W     = ((COL_W > WID_W) ? COL_W : WID_W) + 1;
   localparam int ROW_W      = HGT_W;
   localparam int ROWX_W     = ROW_W + 1;
   localparam int SLOT_W     = $clog2(RADIUS * MAX_WIDTH + RADIUS
                                      + WIDTH_CAP * HEIGHT_CAP + 1);
   localparam int BANK_W     = $clog2(KSIZE);

   // Datapath widths
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int IDX_W      = 8;
   localparam int PROD_W     = PIX_W + COEF_W;
   localparam int TREE_DEPTH = $clog2(TAPS);
   localparam int TREE_LEAVES = 1 << TREE_DEPTH;
   localparam int SUM_W      = PROD_W + TREE_DEPTH;
   localparam int FRAC_W     = 16;
   localparam int ROUND_HALF = 1 << (FRAC_W - 1);
   localparam int PIX_MAX    = (1 << PIX_W) - 1;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = HGT_W;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd512;
   localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd512;

   typedef enum logic [1:0] {
      OP_COEF  = 2'd0,
      OP_PIXEL = 2'd1,
      OP_DRAIN = 2'd2
   } gwc_op_type;

   typedef struct packed {
      gwc_op_type          opcode;
      logic [IDX_W-1:0]    coef_index;
      logic [COEF_W-1:0]   coef_value;
      logic [PIX_W-1:0]    pixel_in;
   } gwc_req_type;

   typedef struct packed {
      logic [PIX_W-1:0]    pixel_out;
      logic                frame_last;
   } gwc_rsp_type;

   // Per-cell control
   typedef struct packed {
      logic shift;
      logic mult;
      logic keep;
      logic coef_we;
   } gwc_cell_ctl_type;

endpackage

>>> rtl/core/gwc_line_bank.sv
// ----------------------------------------------------------------------------
// gwc_line_bank
// One row of the line store: single write port, registered read port.
// ----------------------------------------------------------------------------
module gwc_line_bank import gwc_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem [MAX_WIDTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/gwc_tap_cell.sv
// ----------------------------------------------------------------------------
// gwc_tap_cell
// One window tap: pixel register shifted from its neighbour, its kernel
// coefficient and a registered product.
// ----------------------------------------------------------------------------
module gwc_tap_cell import gwc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  gwc_cell_ctl_type  ctl,
   input  logic [COEF_W-1:0] coef_value,
   input  logic [PIX_W-1:0]  pix_in,
   output logic [PIX_W-1:0]  pix_out,
   output logic [PROD_W-1:0] prod_out
);

   logic [PIX_W-1:0]  pix_ff;
   logic [COEF_W-1:0] coef_ff;
   logic [PROD_W-1:0] prod_ff;

   // coefficient, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (ctl.coef_we) begin
         coef_ff <= coef_value;
      end
   end

   // pixel shift and product; taps off the image edge give zero
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         pix_ff <= pix_in;
      end
      if (ctl.mult) begin
         prod_ff <= ctl.keep ? PROD_W'(coef_ff) * PROD_W'(pix_ff) : '0;
      end
   end

   assign pix_out  = pix_ff;
   assign prod_out = prod_ff;

endmodule

>>> rtl/core/gwc_sum_tree.sv
// ----------------------------------------------------------------------------
// gwc_sum_tree
// Registered binary adder tree over all tap products, one level per stage.
// ----------------------------------------------------------------------------
module gwc_sum_tree import gwc_pkg::*; (
   input  logic                  clock,
   input  logic [TREE_DEPTH-1:0] level_en,
   input  logic [PROD_W-1:0]     leaf [TAPS],
   output logic [SUM_W-1:0]      root
);

   // heap order: node n has children 2n+1 and 2n+2
   logic [SUM_W-1:0] node_ff [TREE_LEAVES-1];

   for (genvar n = 0; n < TREE_LEAVES - 1; n++) begin : g_node
      localparam int DEPTH = $clog2(n + 2) - 1;
      localparam int LEFT  = 2 * n + 1;
      localparam int RIGHT = 2 * n + 2;
      logic [SUM_W-1:0] left_val;
      logic [SUM_W-1:0] right_val;

      if (LEFT >= TREE_LEAVES - 1) begin : g_leaf
         localparam int LI = LEFT - (TREE_LEAVES - 1);
         localparam int RI = RIGHT - (TREE_LEAVES - 1);
         if (LI < TAPS) begin : g_l
            assign left_val = SUM_W'(leaf[LI]);
         end else begin : g_lz
            assign left_val = '0;
         end
         if (RI < TAPS) begin : g_r
            assign right_val = SUM_W'(leaf[RI]);
         end else begin : g_rz
            assign right_val = '0;
         end
      end else begin : g_inner
         assign left_val  = node_ff[LEFT];
         assign right_val = node_ff[RIGHT];
      end

      always_ff @(posedge clock) begin
         if (level_en[DEPTH]) begin
            node_ff[n] <= left_val + right_val;
         end
      end
   end

   assign root = node_ff[0];

endmodule

>>> rtl/core/gaussian_window_convolution.sv
// ----------------------------------------------------------------------------
// gaussian_window_convolution
// Raster-order 2D convolution with a square kernel and zero padding.
// ----------------------------------------------------------------------------
//  channel  | ports                          | moves
//  request  | req_valid/req_stall/req_data   | coefficient, pixel or drain
//  response | rsp_valid/rsp_stall/rsp_data   | filtered pixel, frame end flag
//  config   | csr_we/csr_index/csr_data      | image width and height
//
// One pixel or drain transaction per cycle while req_stall is low; a result
// passes the line store read, window shift, multiply, the adder tree levels
// and the output register in that order.
// A coefficient transaction waits until the window stages are empty.
// Reset clears coefficients and frame counters; sizes go to 512 x 512.
// Each stage advances whenever its successor is free, so a response stall
// only backs up the request side once every stage is full.
// ----------------------------------------------------------------------------
module gaussian_window_convolution import gwc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gwc_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gwc_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int NST     = TREE_DEPTH + 4;
   localparam int ST_P0   = 0;
   localparam int ST_WIN  = 1;
   localparam int ST_MUL  = 2;
   localparam int ST_TREE = 3;
   localparam int ST_OUT  = NST - 1;

   // configuration
   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [WID_W-1:0] eff_w;
   logic [HGT_W-1:0] eff_h;

   // frame counters
   logic [COL_W-1:0]  in_col_ff,  in_col_in;
   logic [ROW_W-1:0]  in_row_ff,  in_row_in;
   logic [SLOT_W-1:0] slot_ff,    slot_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [BANK_W-1:0] wptr_ff,    wptr_in;

   // stage control
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] rdy;
   logic [ST_OUT-1:0] last_ff;

   // first and window stage payloads
   logic [PIX_W-1:0] p0_pix_ff;
   logic [KSIZE-1:0] p0_rowmask_ff;
   logic [KSIZE-1:0] p0_colmask_ff;
   logic             p0_emit_ff;
   logic [BANK_W-1:0] p0_bank_ff;
   logic [KSIZE-1:0] win_colmask_ff;

   gwc_rsp_type rsp_ff;

   logic              accept;
   logic              slot_accept;
   logic              emit;
   logic              last;
   logic              row_in_image;
   logic [SLOT_W-1:0] latency;
   logic [KSIZE-1:0]  rowmask;
   logic [KSIZE-1:0]  colmask;
   logic [PIX_W-1:0]  pix_masked;
   logic              win_shift;

   logic [PIX_W-1:0]  rd_data  [KSIZE];
   logic [PIX_W-1:0]  new_col  [KSIZE];
   logic [PIX_W-1:0]  win_pix  [TAPS];
   logic [PROD_W-1:0] prods    [TAPS];
   logic [SUM_W-1:0]  root;
   logic [TREE_DEPTH-1:0] level_en;
   logic [SUM_W:0]    rounded;

   // effective image size
   always_comb begin
      eff_w = width_ff;
      if (width_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (int'(width_ff) > WIDTH_CAP) begin
         eff_w = WID_W'(WIDTH_CAP);
      end
      eff_h = height_ff;
      if (height_ff == '0) begin
         eff_h = HGT_W'(1);
      end else if (int'(height_ff) > HEIGHT_CAP) begin
         eff_h = HGT_W'(HEIGHT_CAP);
      end
   end

   // ready chain, back to front
   always_comb begin
      rdy[ST_OUT] = !valid_ff[ST_OUT] || !rsp_stall;
      for (int k = NST - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k + 1];
      end
   end

   // request handshake; kernel loads wait for the window stages to drain
   always_comb begin
      case (req_data.opcode)
         OP_COEF:  req_stall = valid_ff[ST_P0] || valid_ff[ST_WIN];
         OP_PIXEL,
         OP_DRAIN: req_stall = !rdy[ST_P0];
         default:  req_stall = 1'b0;
      endcase
      accept      = req_valid && !req_stall;
      slot_accept = accept && (req_data.opcode == OP_PIXEL ||
                               req_data.opcode == OP_DRAIN);
   end

   // frame counters and per-slot flags
   always_comb begin
      latency      = SLOT_W'(RADIUS) * SLOT_W'(eff_w) + SLOT_W'(RADIUS);
      emit         = slot_ff >= latency;
      last         = (out_row_ff == eff_h - HGT_W'(1)) &&
                     (WID_W'(out_col_ff) == eff_w - WID_W'(1));
      row_in_image = in_row_ff < eff_h;
      pix_masked   = (req_data.opcode == OP_PIXEL && row_in_image) ?
                     req_data.pixel_in : '0;

      for (int t = 0; t < KSIZE; t++) begin
         rowmask[t] = (ROWX_W'(in_row_ff) + ROWX_W'(t) >= ROWX_W'(2 * RADIUS)) &&
                      (ROWX_W'(in_row_ff) + ROWX_W'(t) <
                       ROWX_W'(eff_h) + ROWX_W'(2 * RADIUS));
      end
      for (int q = 0; q < KSIZE; q++) begin
         colmask[q] = (COLX_W'(out_col_ff) + COLX_W'(q) >= COLX_W'(RADIUS)) &&
                      (COLX_W'(out_col_ff) + COLX_W'(q) <
                       COLX_W'(eff_w) + COLX_W'(RADIUS));
      end

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      slot_in    = slot_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      wptr_in    = wptr_ff;

      if (csr_we) begin
         in_col_in  = '0;
         in_row_in  = '0;
         slot_in    = '0;
         out_col_in = '0;
         out_row_in = '0;
         wptr_in    = '0;
      end else if (slot_accept) begin
         slot_in = slot_ff + SLOT_W'(1);
         if (WID_W'(in_col_ff) + WID_W'(1) >= eff_w) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
            wptr_in   = (int'(wptr_ff) == KSIZE - 1) ? '0 : wptr_ff + BANK_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               slot_in    = '0;
               out_col_in = '0;
               out_row_in = '0;
               wptr_in    = '0;
            end else if (WID_W'(out_col_ff) + WID_W'(1) >= eff_w) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   // configuration and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         slot_ff    <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         wptr_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_data[WID_W-1:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_data[HGT_W-1:0];
               default: ;
            endcase
         end
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         slot_ff    <= slot_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         wptr_ff    <= wptr_in;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[ST_P0]) begin
            valid_ff[ST_P0] <= slot_accept;
         end
         if (rdy[ST_WIN]) begin
            valid_ff[ST_WIN] <= valid_ff[ST_P0] && p0_emit_ff;
         end
         for (int k = ST_MUL; k < NST; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_ff[k - 1];
            end
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (slot_accept) begin
         p0_pix_ff      <= pix_masked;
         p0_rowmask_ff  <= rowmask;
         p0_colmask_ff  <= colmask;
         p0_emit_ff     <= emit;
         p0_bank_ff     <= wptr_ff;
         last_ff[ST_P0] <= emit && last;
      end
      if (rdy[ST_WIN]) begin
         win_colmask_ff  <= p0_colmask_ff;
         last_ff[ST_WIN] <= last_ff[ST_P0];
      end
      for (int k = ST_MUL; k < ST_OUT; k++) begin
         if (rdy[k]) begin
            last_ff[k] <= last_ff[k - 1];
         end
      end
      if (rdy[ST_OUT]) begin
         rsp_ff.frame_last <= last_ff[ST_OUT - 1];
         rsp_ff.pixel_out  <= (rounded[SUM_W:FRAC_W] > (SUM_W + 1 - FRAC_W)'(PIX_MAX)) ?
                              PIX_W'(PIX_MAX) : rounded[FRAC_W + PIX_W - 1:FRAC_W];
      end
   end

   assign rounded = (SUM_W + 1)'(root) + (SUM_W + 1)'(ROUND_HALF);

   // line store ring: one bank per buffered row
   for (genvar b = 0; b < KSIZE; b++) begin : g_bank
      gwc_line_bank u_bank (
         .clock   (clock),
         .wr_en   (slot_accept && row_in_image && (int'(wptr_ff) == b)),
         .wr_addr (in_col_ff),
         .wr_data (pix_masked),
         .rd_en   (slot_accept),
         .rd_addr (in_col_ff),
         .rd_data (rd_data[b])
      );
   end

   // column entering the window, oldest row first
   always_comb begin
      int bsel;
      for (int t = 0; t < KSIZE - 1; t++) begin
         bsel = int'(p0_bank_ff) + 1 + t;
         if (bsel >= KSIZE) begin
            bsel = bsel - KSIZE;
         end
         new_col[t] = p0_rowmask_ff[t] ? rd_data[BANK_W'(bsel)] : '0;
      end
      new_col[KSIZE - 1] = p0_pix_ff;
   end

   assign win_shift = valid_ff[ST_P0] && rdy[ST_WIN];

   // window of tap cells, each row shifting towards column zero
   for (genvar t = 0; t < KSIZE; t++) begin : g_row
      for (genvar q = 0; q < KSIZE; q++) begin : g_col
         localparam int TAP = t * KSIZE + q;
         gwc_cell_ctl_type ctl;
         logic [PIX_W-1:0] pix_next;

         assign ctl.shift   = win_shift;
         assign ctl.mult    = rdy[ST_MUL];
         assign ctl.keep    = win_colmask_ff[q];
         assign ctl.coef_we = accept && (req_data.opcode == OP_COEF) &&
                              (req_data.coef_index == IDX_W'(TAP));

         if (q == KSIZE - 1) begin : g_edge
            assign pix_next = new_col[t];
         end else begin : g_inner
            assign pix_next = win_pix[TAP + 1];
         end

         gwc_tap_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .coef_value (req_data.coef_value),
            .pix_in     (pix_next),
            .pix_out    (win_pix[TAP]),
            .prod_out   (prods[TAP])
         );
      end
   end

   // tree level d uses tree stage TREE_DEPTH-1-d, counted from the first stage after the products
   always_comb begin
      for (int d = 0; d < TREE_DEPTH; d++) begin
         level_en[d] = rdy[ST_TREE + TREE_DEPTH - 1 - d];
      end
   end

   gwc_sum_tree u_tree (
      .clock    (clock),
      .level_en (level_en),
      .leaf     (prods),
      .root     (root)
   );

   assign rsp_valid = valid_ff[ST_OUT];
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/gaussian_window_convolution_test.sv
// ----------------------------------------------------------------------------
// gaussian_window_convolution_test
// Self-checking bench for the windowed image convolution core: a scoreboard
// predicts every filtered pixel from the accepted transactions and compares it
// with each response; small images are streamed with random content, random
// gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module gaussian_window_convolution_test import gwc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         RING_ROWS   = 2 * RADIUS + 2;
   localparam int         CENTRE_TAP  = RADIUS * KSIZE + RADIUS;
   localparam int         DRAIN_WAIT  = TREE_DEPTH + 8;
   localparam int         LONG_HOLD   = 300;
   localparam int         RANDOM_ITEMS = 330;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts filtered pixels and checks the response stream
   // -------------------------------------------------------------------------
   class blur_scoreboard;
      logic [PIX_W-1:0]  row_ring[RING_ROWS][MAX_WIDTH];
      logic [COEF_W-1:0] kernel[TAPS];
      int unsigned       row_pos, col_pos, out_pos;
      int unsigned       width_reg, height_reg;
      gwc_rsp_type       pixel_q[$];
      int                mismatches;
      bit                frame_closed;

      function new();
         foreach (row_ring[r, c]) row_ring[r][c] = '0;
         foreach (kernel[k]) kernel[k] = '0;
         width_reg    = WIDTH_RESET;
         height_reg   = HEIGHT_RESET;
         mismatches   = 0;
         frame_closed = 0;
         restart();
      endfunction

      function void restart();
         row_pos = 0;
         col_pos = 0;
         out_pos = 0;
      endfunction

      function void write_size(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_IMAGE_WIDTH) width_reg = val[WID_W-1:0];
         else height_reg = val[HGT_W-1:0];
         restart();
      endfunction

      function int unsigned eff_width();
         int unsigned w;
         w = (width_reg == 0) ? 1 : width_reg;
         return (w > MAX_WIDTH) ? MAX_WIDTH : w;
      endfunction

      function int unsigned eff_height();
         int unsigned h;
         h = (height_reg == 0) ? 1 : height_reg;
         return (h > HEIGHT_CAP) ? HEIGHT_CAP : h;
      endfunction

      // zero-padded window sum, rounded and clipped
      function logic [PIX_W-1:0] blur_at(int r, int c, int w, int h);
         longint unsigned acc;
         int rr, cc;
         logic [PIX_W-1:0] p;
         acc = 0;
         for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
            for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
               rr = r + dy;
               cc = c + dx;
               p = '0;
               if (rr >= 0 && cc >= 0 && rr < h && cc < w) p = row_ring[rr % RING_ROWS][cc];
               acc += longint'(kernel[(dy + RADIUS) * KSIZE + dx + RADIUS]) * longint'(p);
            end
         end
         acc = (acc + ROUND_HALF) >> FRAC_W;
         return (acc > PIX_MAX) ? PIX_MAX[PIX_W-1:0] : acc[PIX_W-1:0];
      endfunction

      function void note_request(gwc_req_type t);
         int unsigned w, h, total, slot;
         gwc_rsp_type e;
         if (t.opcode == OP_COEF) begin
            if (t.coef_index < TAPS) kernel[t.coef_index] = t.coef_value;
            return;
         end
         if (t.opcode != OP_PIXEL && t.opcode != OP_DRAIN) return;
         w = eff_width();
         h = eff_height();
         total = w * h;
         slot = row_pos * w + col_pos;
         if (slot < total)
            row_ring[row_pos % RING_ROWS][col_pos] = (t.opcode == OP_PIXEL) ? t.pixel_in : '0;
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (slot >= RADIUS * w + RADIUS && out_pos < total) begin
            e.pixel_out  = blur_at(out_pos / w, out_pos % w, w, h);
            e.frame_last = (out_pos + 1 == total);
            pixel_q.push_back(e);
            out_pos++;
            if (e.frame_last) begin
               frame_closed = 1;
               restart();
            end
         end
      endfunction

      function void check_result(gwc_rsp_type got);
         gwc_rsp_type e;
         if (pixel_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response: pixel %0d last %0b",
                                           got.pixel_out, got.frame_last);
            return;
         end
         e = pixel_q.pop_front();
         if (got.pixel_out !== e.pixel_out || got.frame_last !== e.frame_last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: pixel exp %0d got %0d, last exp %0b got %0b",
                        e.pixel_out, got.pixel_out, e.frame_last, got.frame_last);
         end
      endfunction

      function int pending();
         return pixel_q.size();
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   gwc_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   gwc_rsp_type           rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   blur_scoreboard sb = new();
   int  burst_left = 0;
   int  item_count = 0;
   int  hold_asks  = 0;
   int  hold_seen  = 0;

   gaussian_window_convolution dut (.*);

   always #4 clock = ~clock;

   // Generous ceiling on the whole run
   initial begin
      #3ms;
      $display("Some tests failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: stall pattern in phases, plus long hold-offs on request
   // -------------------------------------------------------------------------
   initial begin
      int phase_mode, phase_left, hold_left;
      rsp_stall = 0;
      phase_mode = 0;
      phase_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (phase_left == 0) begin
            phase_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(16, 96);
         end
         phase_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1;
         end else begin
            case (phase_mode)
               0: rsp_stall = 0;
               1: rsp_stall = ($urandom_range(0, 99) < 30);
               2: rsp_stall = ~rsp_stall;
               default: rsp_stall = ($urandom_range(0, 99) < 75);
            endcase
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   task automatic send_item(gwc_req_type t);
      @(negedge clock);
      req_valid = 1;
      req_data  = t;
      do @(posedge clock); while (req_stall);
      sb.note_request(t);
      item_count++;
      if (burst_left > 0) burst_left--;
      else begin
         @(negedge clock);
         req_valid = 0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic send_op(gwc_op_type op, int idx, int val, int pix);
      gwc_req_type t;
      t.opcode     = op;
      t.coef_index = idx[IDX_W-1:0];
      t.coef_value = val[COEF_W-1:0];
      t.pixel_in   = pix[PIX_W-1:0];
      send_item(t);
   endtask

   task automatic send_unused();
      gwc_req_type t;
      t = gwc_req_type'($urandom());
      t.opcode = gwc_op_type'(OP_UNUSED);
      send_item(t);
   endtask

   // wait for every expected pixel, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // the request side goes idle so that no transaction is taken twice
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      req_valid = 0;
      csr_we    = 1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      sb.write_size(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   // stream one image, with optional noise among the pixels, then drain it out
   task automatic run_frame(int w, int h, bit noisy);
      int n, pick;
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      sb.frame_closed = 0;
      n = 0;
      while (n < sb.eff_width() * sb.eff_height()) begin
         pick = noisy ? $urandom_range(0, 99) : 0;
         if (pick < 82) begin
            send_op(OP_PIXEL, $urandom(), $urandom(), $urandom());
            n++;
         end else if (pick < 88) begin
            send_op(OP_DRAIN, $urandom(), $urandom(), $urandom());
            n++;
         end else if (pick < 93) send_op(OP_COEF, $urandom_range(0, TAPS - 1),
                                         $urandom_range(0, 900), 0);
         else if (pick < 96) send_op(OP_COEF, $urandom_range(TAPS, 255), $urandom(), 0);
         else send_unused();
      end
      // pixels past the image end behave as padding
      while (!sb.frame_closed) begin
         if (noisy && $urandom_range(0, 3) == 0)
            send_op(OP_PIXEL, $urandom(), $urandom(), $urandom());
         else send_op(OP_DRAIN, $urandom(), $urandom(), $urandom());
      end
      settle();
   endtask

   initial begin
      int stop_at, frames;
      reset     = 1;
      req_valid = 0;
      req_data  = '0;
      csr_we    = 0;
      csr_index = '0;
      csr_data  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: kernel corners and centre, ignored indexes, unused opcode
      send_op(OP_COEF, CENTRE_TAP, 65535, 0);
      send_op(OP_COEF, 0, 32768, 0);
      send_op(OP_COEF, TAPS - 1, 32767, 0);
      send_op(OP_COEF, TAPS, 65535, 0);
      send_op(OP_COEF, 255, 65535, 0);
      send_unused();
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(3));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(2));
      sb.frame_closed = 0;
      send_op(OP_PIXEL, 0, 0, 255);
      send_op(OP_PIXEL, 0, 0, 0);
      send_op(OP_PIXEL, 0, 0, 85);
      send_op(OP_DRAIN, 0, 0, 255);   // padding inside the image reads as zero
      send_op(OP_PIXEL, 0, 0, 170);
      send_op(OP_PIXEL, 0, 0, 255);
      while (!sb.frame_closed) send_op(OP_PIXEL, 0, 0, 255);
      settle();
      // zero sizes read as one pixel
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(0));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(0));
      sb.frame_closed = 0;
      while (!sb.frame_closed) send_op(OP_PIXEL, 0, 0, 255);
      settle();
      // height above the cap, then a short row fed past its end
      write_csr(CSR_IMAGE_HEIGHT, 13'h1FFF);
      sb.frame_closed = 0;
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(5));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(1));
      for (int i = 0; i < 12; i++) send_op(OP_PIXEL, 0, 0, $urandom());
      while (!sb.frame_closed) send_op(OP_DRAIN, 0, 0, 0);
      settle();

      // Saturating taps around the centre on a tiny image
      for (int k = CENTRE_TAP - 1; k <= CENTRE_TAP + 1; k++) send_op(OP_COEF, k, 65535, 0);
      send_op(OP_COEF, CENTRE_TAP - KSIZE, 65535, 0);
      send_op(OP_COEF, CENTRE_TAP + KSIZE, 65535, 0);
      run_frame(2, 2, 0);
      // Moderate weights over the middle rows so that sums land in range
      for (int k = CENTRE_TAP - KSIZE - 1; k <= CENTRE_TAP + KSIZE + 1; k++)
         send_op(OP_COEF, k, $urandom_range(0, 600), 0);

      // Random images
      stop_at = item_count + RANDOM_ITEMS;
      frames = 0;
      while (item_count < stop_at) begin
         if (frames == 0) hold_asks++;   // long response hold-off backs up the input
         for (int k = 0; k < 4; k++)
            send_op(OP_COEF, $urandom_range(0, TAPS - 1),
                    ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 700), 0);
         if ($urandom_range(0, 4) == 0) run_frame($urandom_range(1, 24), $urandom_range(1, 3), 1);
         else run_frame($urandom_range(1, 12), $urandom_range(1, 8), 1);
         frames++;
      end

      settle();
      if (sb.mismatches == 0 && sb.pending() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
